// File: rtl/tmp_pkg.sv
package tmp_pkg;

	localparam int WIDE_BITS = 64;
	localparam int WIDE_LIMIT_BIT = 60;

	typedef logic signed [WIDE_BITS-1:0] wide_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

	function automatic logic [WIDE_BITS-1:0] mag(input wide_t x);
		return x < 0 ? $unsigned(-x) : $unsigned(x);
	endfunction

endpackage

// File: rtl/tmp_unit.sv
module tmp_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tmp_pkg::unit_req_t  req,
	input  tmp_pkg::wide_t      a,
	input  tmp_pkg::wide_t      b,
	output tmp_pkg::unit_rsp_t  rsp,
	output tmp_pkg::wide_t      result
);

	localparam int WB = tmp_pkg::WIDE_BITS;
	localparam int MB = WORD_BITS + 4;
	localparam int PW = WB + MB;
	localparam int RW = WORD_BITS + 2;
	localparam int CW = $clog2(WB + 1);
	localparam tmp_pkg::wide_t SMAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
	localparam tmp_pkg::wide_t SMIN = -SMAX - 64'sd1;

	typedef enum logic [1:0] {
		U_IDLE,
		U_RUN,
		U_FIN
	} ustate_t;

	ustate_t           state_q;
	tmp_pkg::unit_op_t op_q;
	logic              neg_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     acc_q;
	logic [PW-1:0]     opd_q;
	logic [WB-1:0]     d_q;
	logic [WB-1:0]     mb_q;
	tmp_pkg::wide_t    result_q;

	logic [WB-1:0]     ma;
	logic [WB-1:0]     mbm;
	logic [WB:0]       r_div;
	logic [RW-1:0]     r_sq;
	logic [RW-1:0]     trial;
	logic [PW-1:0]     prod;
	logic [WB-1:0]     prod_c;
	tmp_pkg::wide_t    sq_in;

	always_comb begin
		ma = tmp_pkg::mag(a);
		mbm = tmp_pkg::mag(b);
		r_div = {acc_q[WB-1:0], opd_q[WB-1]};
		r_sq = {acc_q[RW-3:0], opd_q[2*WORD_BITS-1 -: 2]};
		trial = {mb_q[WORD_BITS-1:0], 2'b01};
		prod = acc_q >> FRACTION_BITS;
		if (prod[PW-1:tmp_pkg::WIDE_LIMIT_BIT] != '0) begin
			prod_c = WB'(1) << tmp_pkg::WIDE_LIMIT_BIT;
		end else begin
			prod_c = prod[WB-1:0];
		end
		sq_in = (a > SMAX) ? SMAX : a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q <= 1'b0;
			op_q <= tmp_pkg::OP_MUL;
			neg_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						neg_q <= (a < 0) != (b < 0);
						acc_q <= '0;
						mb_q <= '0;
						unique case (req.op)
							tmp_pkg::OP_MUL: begin
								opd_q <= PW'(ma);
								d_q <= mbm;
								cnt_q <= CW'(MB);
								state_q <= U_RUN;
							end
							tmp_pkg::OP_DIV: begin
								opd_q <= PW'(ma << FRACTION_BITS);
								d_q <= mbm;
								cnt_q <= CW'(WB);
								if (ma == '0) begin
									result_q <= '0;
									done_q <= 1'b1;
								end else if (mbm == '0) begin
									result_q <= ((a < 0) != (b < 0)) ? SMIN : SMAX;
									done_q <= 1'b1;
								end else begin
									state_q <= U_RUN;
								end
							end
							default: begin
								opd_q <= (PW'($unsigned(sq_in)) << FRACTION_BITS)
									| ((PW'(1) << FRACTION_BITS) - PW'(1));
								cnt_q <= CW'(WORD_BITS);
								if (a <= 0) begin
									result_q <= '0;
									done_q <= 1'b1;
								end else begin
									state_q <= U_RUN;
								end
							end
						endcase
					end
				end
				U_RUN: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= U_FIN;
					end
					unique case (op_q)
						tmp_pkg::OP_MUL: begin
							if (d_q[0]) begin
								acc_q <= acc_q + opd_q;
							end
							opd_q <= opd_q << 1;
							d_q <= d_q >> 1;
						end
						tmp_pkg::OP_DIV: begin
							if (r_div >= {1'b0, d_q}) begin
								acc_q <= PW'(r_div - {1'b0, d_q});
								mb_q <= {mb_q[WB-2:0], 1'b1};
							end else begin
								acc_q <= PW'(r_div);
								mb_q <= {mb_q[WB-2:0], 1'b0};
							end
							opd_q <= opd_q << 1;
						end
						default: begin
							if (r_sq >= trial) begin
								acc_q <= PW'(r_sq - trial);
								mb_q <= {mb_q[WB-2:0], 1'b1};
							end else begin
								acc_q <= PW'(r_sq);
								mb_q <= {mb_q[WB-2:0], 1'b0};
							end
							opd_q <= opd_q << 2;
						end
					endcase
				end
				default: begin
					done_q <= 1'b1;
					state_q <= U_IDLE;
					unique case (op_q)
						tmp_pkg::OP_MUL: begin
							result_q <= neg_q ? -$signed(prod_c) : $signed(prod_c);
						end
						tmp_pkg::OP_DIV: begin
							if (mb_q[WB-1:WORD_BITS-1] != '0) begin
								result_q <= neg_q ? SMIN : SMAX;
							end else begin
								result_q <= neg_q ? -$signed(mb_q) : $signed(mb_q);
							end
						end
						default: begin
							result_q <= ($signed(mb_q) > SMAX) ? SMAX : $signed(mb_q);
						end
					endcase
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign result = result_q;

endmodule

// File: rtl/trapezoidal_motion_profile.sv
// Trapezoidal motion profile generator in signed fixed point (FRACTION_BITS fraction bits).
// Each transfer on the slave side carries a target position and the time elapsed since that
// target was issued; each one yields exactly one transfer on the master side with position,
// velocity, acceleration and a finished flag. A new target replans brake, accel, cruise and
// decel segments (triangular with a square-root peak when no cruise fits). All multiplies,
// divisions and roots run on one shared unit. An item for an unchanged target needs up to 3
// multiplies; a changed target adds up to 6 divisions, 6 multiplies and one root. s_tready is
// high only while the sequencer is idle.
module trapezoidal_motion_profile #(
	parameter int WORD_BITS = 32,
	parameter int FRACTION_BITS = 16,
	localparam int IN_W = ((2 * WORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * WORD_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [WORD_BITS-1:0] cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // target_position, elapsed_time
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,  // position_out, velocity_out, acceleration_out
	output logic                 m_tuser   // finished
);

	localparam int W = WORD_BITS;
	localparam int WB = tmp_pkg::WIDE_BITS;
	localparam tmp_pkg::wide_t SMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam tmp_pkg::wide_t SMIN = -SMAX - 64'sd1;
	localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
	localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
	localparam logic [1:0] REG_INITIAL_POSITION = 2'd2;
	localparam logic signed [1:0] SIGN_POS = 2'sb01;
	localparam logic signed [1:0] SIGN_NEG = 2'sb11;
	localparam logic signed [1:0] SIGN_ZERO = 2'sb00;

	typedef logic signed [W-1:0] word_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_BT, S_BD, S_SIGN, S_AT, S_AD, S_DT, S_DD, S_CT,
		S_PV, S_PA, S_PS, S_PT, S_PD, S_PE, S_SEL, S_M1, S_M2, S_M3, S_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEG_RAMP, SEG_CRUISE, SEG_DECEL, SEG_DONE
	} seg_t;

	function automatic tmp_pkg::wide_t ext(input word_t v);
		return {{(WB - W){v[W-1]}}, v};
	endfunction

	function automatic word_t sat_w(input tmp_pkg::wide_t x);
		if (x > SMAX) begin
			return SMAX[W-1:0];
		end
		if (x < SMIN) begin
			return SMIN[W-1:0];
		end
		return x[W-1:0];
	endfunction

	function automatic tmp_pkg::wide_t half(input tmp_pkg::wide_t x);
		return (x + ((x < 0) ? 64'sd1 : 64'sd0)) >>> 1;
	endfunction

	function automatic logic signed [1:0] sgn(input tmp_pkg::wide_t x);
		return (x < 0) ? SIGN_NEG : ((x > 0) ? SIGN_POS : SIGN_ZERO);
	endfunction

	function automatic tmp_pkg::wide_t smul(input logic signed [1:0] s, input tmp_pkg::wide_t x);
		return (s == SIGN_POS) ? x : ((s == SIGN_NEG) ? -x : 64'sd0);
	endfunction

	state_t            state_q;
	seg_t              seg_q;
	logic              busy_q;
	logic [W-2:0]      vmax_q;
	logic [W-2:0]      amax_q;
	word_t             target_q;
	logic [W-1:0]      dt_q;
	word_t             last_target_q;
	word_t             start_pos_q;
	word_t             start_vel_q;
	word_t             cur_pos_q;
	word_t             cur_vel_q;
	logic signed [1:0] sign_q;
	logic              trap_q;
	logic              brake_q;
	word_t             brake_time_q;
	word_t             accel_time_q;
	word_t             cruise_time_q;
	word_t             decel_time_q;
	word_t             brake_dist_q;
	word_t             accel_dist_q;
	word_t             cruise_dist_q;
	word_t             peak_q;
	logic              finished_q;
	word_t             total_q;
	tmp_pkg::wide_t    av0_q;
	tmp_pkg::wide_t    tmp_q;
	tmp_pkg::wide_t    u_q;
	tmp_pkg::wide_t    m1_q;
	tmp_pkg::wide_t    m2_q;
	tmp_pkg::wide_t    m3_q;
	logic              m_tvalid_q;
	word_t             pos_out_q;
	word_t             vel_out_q;
	word_t             acc_out_q;
	logic              fin_out_q;

	tmp_pkg::unit_req_t req;
	tmp_pkg::unit_rsp_t rsp;
	tmp_pkg::wide_t     ua;
	tmp_pkg::wide_t     ub;
	tmp_pkg::wide_t     res;
	logic               call;

	tmp_pkg::wide_t vmax_w, amax_w, v0_w, target_w, start_w, dt_w, peak_w;
	tmp_pkg::wide_t bd_keep, t1, t2, pk, base;
	logic signed [1:0] sv0, sg;
	logic brk;
	tmp_pkg::wide_t fin_pos, fin_vel, fin_acc;
	logic fin_done;

	always_comb begin
		vmax_w = {{(WB - W + 1){1'b0}}, vmax_q};
		amax_w = {{(WB - W + 1){1'b0}}, amax_q};
		v0_w = ext(start_vel_q);
		target_w = ext(target_q);
		start_w = ext(start_pos_q);
		dt_w = {{(WB - W){1'b0}}, dt_q};
		peak_w = ext(peak_q);
		sv0 = sgn(v0_w);
		sg = sgn(target_w - (start_w + smul(sv0, ext(brake_dist_q))));
		brk = sg != sv0;
		bd_keep = brk ? ext(brake_dist_q) : 64'sd0;
		t1 = ext(brake_time_q) + ext(accel_time_q);
		t2 = trap_q ? t1 + ext(cruise_time_q) : t1;
		pk = trap_q ? vmax_w : peak_w;
		base = ext(accel_dist_q) - ext(brake_dist_q) + (trap_q ? ext(cruise_dist_q) : 64'sd0);
	end

	always_comb begin
		call = 1'b1;
		req.op = tmp_pkg::OP_MUL;
		ua = '0;
		ub = '0;
		unique case (state_q)
			S_BT: begin
				req.op = tmp_pkg::OP_DIV;
				ua = av0_q;
				ub = amax_w;
			end
			S_BD: begin
				ua = ext(brake_time_q);
				ub = av0_q;
			end
			S_AT: begin
				req.op = tmp_pkg::OP_DIV;
				ua = brake_q ? vmax_w : vmax_w - av0_q;
				ub = amax_w;
			end
			S_AD: begin
				ua = ext(accel_time_q);
				ub = brake_q ? vmax_w : vmax_w + av0_q;
			end
			S_DT, S_PE: begin
				req.op = tmp_pkg::OP_DIV;
				ua = (state_q == S_DT) ? vmax_w : peak_w;
				ub = amax_w;
			end
			S_DD: begin
				ua = ext(decel_time_q);
				ub = vmax_w;
			end
			S_CT: begin
				req.op = tmp_pkg::OP_DIV;
				ua = ext(cruise_dist_q);
				ub = vmax_w;
			end
			S_PV: begin
				ua = v0_w;
				ub = v0_w;
			end
			S_PA: begin
				ua = ext(total_q);
				ub = amax_w;
			end
			S_PS: begin
				req.op = tmp_pkg::OP_SQRT;
				ua = tmp_q;
			end
			S_PT: begin
				req.op = tmp_pkg::OP_DIV;
				ua = brake_q ? peak_w : peak_w - av0_q;
				ub = amax_w;
			end
			S_PD: begin
				ua = ext(accel_time_q);
				ub = brake_q ? peak_w : peak_w + av0_q;
			end
			S_M1: begin
				ua = u_q;
				ub = (seg_q == SEG_CRUISE) ? vmax_w : amax_w;
			end
			S_M2: begin
				ua = m1_q;
				ub = u_q;
			end
			S_M3: begin
				ua = u_q;
				ub = (seg_q == SEG_RAMP) ? v0_w : pk;
			end
			default: call = 1'b0;
		endcase
		req.start = call && !busy_q;
	end

	always_comb begin
		fin_done = 1'b0;
		fin_acc = 64'sd0;
		unique case (seg_q)
			SEG_RAMP: begin
				fin_pos = start_w + m3_q + smul(sign_q, half(m2_q));
				fin_vel = v0_w + smul(sign_q, m1_q);
				fin_acc = smul(sign_q, amax_w);
			end
			SEG_CRUISE: begin
				fin_pos = start_w + smul(sign_q, ext(accel_dist_q) - ext(brake_dist_q) + m1_q);
				fin_vel = smul(sign_q, vmax_w);
			end
			SEG_DECEL: begin
				fin_pos = start_w + smul(sign_q, base + m3_q - half(m2_q));
				fin_vel = smul(sign_q, pk - m1_q);
				fin_acc = -smul(sign_q, amax_w);
			end
			default: begin
				fin_pos = target_w;
				fin_vel = 64'sd0;
				fin_done = 1'b1;
			end
		endcase
	end

	tmp_unit #(
		.WORD_BITS(WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.a(ua),
		.b(ub),
		.rsp(rsp),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seg_q <= SEG_DONE;
			busy_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			vmax_q <= (W - 1)'(1) << FRACTION_BITS;
			amax_q <= (W - 1)'(1) << FRACTION_BITS;
			last_target_q <= '0;
			start_pos_q <= '0;
			start_vel_q <= '0;
			cur_pos_q <= '0;
			cur_vel_q <= '0;
			sign_q <= SIGN_POS;
			trap_q <= 1'b1;
			brake_q <= 1'b0;
			brake_time_q <= '0;
			accel_time_q <= '0;
			cruise_time_q <= '0;
			decel_time_q <= '0;
			brake_dist_q <= '0;
			accel_dist_q <= '0;
			cruise_dist_q <= '0;
			peak_q <= '0;
			finished_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_VELOCITY: vmax_q <= cfg_data[W-2:0];
					REG_MAX_ACCELERATION: amax_q <= cfg_data[W-2:0];
					REG_INITIAL_POSITION: begin
						cur_pos_q <= cfg_data;
						start_pos_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (rsp.done) begin
				busy_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						target_q <= s_tdata[W-1:0];
						dt_q <= s_tdata[2*W-1:W];
						state_q <= (s_tdata[W-1:0] != last_target_q) ? S_INIT : S_SEL;
					end
				end
				S_INIT: begin
					finished_q <= 1'b0;
					last_target_q <= target_q;
					start_pos_q <= cur_pos_q;
					start_vel_q <= cur_vel_q;
					av0_q <= $signed(tmp_pkg::mag(ext(cur_vel_q)));
					state_q <= S_BT;
				end
				S_SIGN: begin
					sign_q <= sg;
					brake_q <= brk;
					if (!brk) begin
						brake_time_q <= '0;
						brake_dist_q <= '0;
					end
					total_q <= sat_w($signed(tmp_pkg::mag(target_w - start_w + smul(sg, bd_keep))));
					state_q <= S_AT;
				end
				S_SEL: begin
					if (dt_w <= t1) begin
						seg_q <= SEG_RAMP;
						u_q <= dt_w;
						state_q <= S_M1;
					end else if (trap_q && dt_w < t2) begin
						seg_q <= SEG_CRUISE;
						u_q <= dt_w - t1;
						state_q <= S_M1;
					end else if (dt_w < t2 + ext(decel_time_q)) begin
						seg_q <= SEG_DECEL;
						u_q <= dt_w - t2;
						state_q <= S_M1;
					end else begin
						seg_q <= SEG_DONE;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						cur_pos_q <= sat_w(fin_pos);
						cur_vel_q <= sat_w(fin_vel);
						pos_out_q <= sat_w(fin_pos);
						vel_out_q <= sat_w(fin_vel);
						acc_out_q <= sat_w(fin_acc);
						fin_out_q <= finished_q || fin_done;
						if (fin_done) begin
							finished_q <= 1'b1;
						end
						m_tvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					if (rsp.done) begin
						unique case (state_q)
							S_BT: begin
								brake_time_q <= res[W-1:0];
								state_q <= S_BD;
							end
							S_BD: begin
								brake_dist_q <= sat_w(half(res));
								state_q <= S_SIGN;
							end
							S_AT: begin
								accel_time_q <= res[W-1:0];
								state_q <= S_AD;
							end
							S_AD: begin
								accel_dist_q <= sat_w(half(res));
								state_q <= S_DT;
							end
							S_DT: begin
								decel_time_q <= res[W-1:0];
								state_q <= S_DD;
							end
							S_DD: begin
								cruise_dist_q <= sat_w(ext(total_q)
									- (ext(accel_dist_q) + ext(sat_w(half(res)))));
								state_q <= S_CT;
							end
							S_CT: begin
								cruise_time_q <= res[W-1:0];
								if (res > 0) begin
									trap_q <= 1'b1;
									state_q <= S_SEL;
								end else begin
									trap_q <= 1'b0;
									tmp_q <= '0;
									if (brake_q) begin
										state_q <= S_PA;
									end else begin
										total_q <= sat_w($signed(tmp_pkg::mag(target_w - start_w)));
										state_q <= S_PV;
									end
								end
							end
							S_PV: begin
								tmp_q <= half(res);
								state_q <= S_PA;
							end
							S_PA: begin
								tmp_q <= tmp_q + res;
								state_q <= S_PS;
							end
							S_PS: begin
								peak_q <= res[W-1:0];
								state_q <= S_PT;
							end
							S_PT: begin
								accel_time_q <= res[W-1:0];
								state_q <= S_PD;
							end
							S_PD: begin
								accel_dist_q <= sat_w(half(res));
								state_q <= S_PE;
							end
							S_PE: begin
								decel_time_q <= res[W-1:0];
								state_q <= S_SEL;
							end
							S_M1: begin
								m1_q <= res;
								state_q <= (seg_q == SEG_CRUISE) ? S_FIN : S_M2;
							end
							S_M2: begin
								m2_q <= res;
								state_q <= S_M3;
							end
							default: begin
								m3_q <= res;
								state_q <= S_FIN;
							end
						endcase
					end
				end
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = OUT_W'({acc_out_q, vel_out_q, pos_out_q});
	assign m_tuser = fin_out_q;

endmodule

// File: test/tb_trapezoidal_motion_profile.sv
`timescale 1ns / 1ps

module tb_trapezoidal_motion_profile;

	localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
	localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
	localparam logic [1:0] REG_INITIAL_POSITION = 2'd2;
	localparam logic [1:0] REG_UNUSED           = 2'd3;
	localparam int WATCHDOG_LIMIT = 60000;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam longint unsigned CMASK = 64'h7FFF_FFFF;
	localparam longint unsigned WIDE = 64'h1000_0000_0000_0000;

	typedef struct {
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
		logic        fin;
	} setpoint_t;

	class profile_scoreboard;
		longint vmax, amax, last_tgt, start_pos, start_vel, cur_pos, cur_vel, dir;
		bit trapezoid, done_flag;
		longint t_brake, t_accel, t_cruise, t_decel, d_brake, d_accel, d_cruise, v_peak;
		setpoint_t pending[$];
		int errors;

		function new();
			vmax = 65536;
			amax = 65536;
			last_tgt = 0;
			start_pos = 0;
			cur_pos = 0;
			start_vel = 0;
			cur_vel = 0;
			dir = 1;
			trapezoid = 1;
			t_brake = 0; t_accel = 0; t_cruise = 0; t_decel = 0;
			d_brake = 0; d_accel = 0; d_cruise = 0; v_peak = 0;
			done_flag = 0;
			errors = 0;
		endfunction

		function longint sat(longint x);
			if (x > SMAX) return SMAX;
			if (x < SMIN) return SMIN;
			return x;
		endfunction

		function longint unsigned mag(longint x);
			return x < 0 ? -x : x;
		endfunction

		function longint sgn(longint x);
			return x < 0 ? -1 : (x > 0 ? 1 : 0);
		endfunction

		function longint unsigned umulq(longint unsigned a, longint unsigned b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			if ((p >> 80) != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
			return p[79:16];
		endfunction

		function longint fmul(longint a, longint b);
			longint unsigned m;
			longint r;
			m = umulq(mag(a), mag(b));
			if (m > WIDE) m = WIDE;
			r = m;
			return ((a < 0) != (b < 0)) ? -r : r;
		endfunction

		function longint fdiv(longint a, longint b);
			longint unsigned n, d, q, rem;
			bit neg;
			n = mag(a);
			d = mag(b);
			neg = (a < 0) != (b < 0);
			if (n == 0) return 0;
			if (d == 0) return neg ? SMIN : SMAX;
			q = n / d;
			rem = n % d;
			if (q > (CMASK >> 16)) return neg ? SMIN : SMAX;
			for (int i = 0; i < 16; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= d) begin
					rem = rem - d;
					q = q | 1;
				end
			end
			if (q > CMASK) q = CMASK;
			return neg ? -longint'(q) : longint'(q);
		endfunction

		function longint fsqrt(longint x);
			longint unsigned r, c;
			r = 0;
			x = sat(x);
			if (x <= 0) return 0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (umulq(c, c) <= longint'(x)) r = c;
			end
			return sat(r);
		endfunction

		function longint absw(longint x);
			return x < 0 ? -x : x;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_MAX_VELOCITY: vmax = value[30:0];
				REG_MAX_ACCELERATION: amax = value[30:0];
				REG_INITIAL_POSITION: begin
					cur_pos = longint'($signed(value));
					start_pos = cur_pos;
				end
				default: ;
			endcase
		endfunction

		function void replan(longint tgt);
			longint av0, total, ddec;
			bit brake;
			done_flag = 0;
			last_tgt = tgt;
			start_pos = cur_pos;
			start_vel = cur_vel;
			av0 = absw(start_vel);
			t_brake = fdiv(av0, amax);
			d_brake = sat(fmul(t_brake, av0) / 2);
			dir = sgn(tgt - (start_pos + sgn(start_vel) * d_brake));
			brake = dir != sgn(start_vel);
			if (brake) begin
				t_accel = fdiv(vmax, amax);
				d_accel = sat(fmul(t_accel, vmax) / 2);
			end else begin
				t_brake = 0;
				d_brake = 0;
				t_accel = fdiv(vmax - av0, amax);
				d_accel = sat(fmul(t_accel, vmax + av0) / 2);
			end
			total = sat(absw(tgt - start_pos + dir * d_brake));
			t_decel = fdiv(vmax, amax);
			ddec = sat(fmul(t_decel, vmax) / 2);
			d_cruise = sat(total - (d_accel + ddec));
			t_cruise = fdiv(d_cruise, vmax);
			if (t_cruise > 0) begin
				trapezoid = 1;
				return;
			end
			trapezoid = 0;
			if (brake) begin
				v_peak = fsqrt(fmul(amax, total));
				t_accel = fdiv(v_peak, amax);
				d_accel = sat(fmul(t_accel, v_peak) / 2);
			end else begin
				t_brake = 0;
				d_brake = 0;
				total = sat(absw(tgt - start_pos));
				v_peak = fsqrt(fmul(start_vel, start_vel) / 2 + fmul(amax, total));
				t_accel = fdiv(v_peak - av0, amax);
				d_accel = sat(fmul(t_accel, v_peak + av0) / 2);
			end
			t_decel = fdiv(v_peak, amax);
		endfunction

		function void note_input(logic [31:0] tgt_bits, logic [31:0] dt_bits);
			longint tgt, dt, t1, t2, pk, base, u, pos, vel, acc;
			setpoint_t e;
			tgt = longint'($signed(tgt_bits));
			dt = longint'({32'd0, dt_bits});
			if (tgt != last_tgt) replan(tgt);
			t1 = t_brake + t_accel;
			if (dt <= t1) begin
				pos = start_pos + fmul(start_vel, dt) + dir * (fmul(fmul(amax, dt), dt) / 2);
				vel = start_vel + dir * fmul(amax, dt);
				acc = dir * amax;
			end else begin
				if (trapezoid) begin
					t2 = t1 + t_cruise;
					pk = vmax;
					base = d_accel - d_brake + d_cruise;
				end else begin
					t2 = t1;
					pk = v_peak;
					base = d_accel - d_brake;
				end
				if (trapezoid && dt < t2) begin
					pos = start_pos + dir * (d_accel - d_brake + fmul(vmax, dt - t1));
					vel = dir * vmax;
					acc = 0;
				end else if (dt < t2 + t_decel) begin
					u = dt - t2;
					pos = start_pos + dir * (base + fmul(pk, u) - fmul(fmul(amax, u), u) / 2);
					vel = dir * (pk - fmul(amax, u));
					acc = -dir * amax;
				end else begin
					pos = tgt;
					vel = 0;
					acc = 0;
					done_flag = 1;
				end
			end
			cur_pos = sat(pos);
			cur_vel = sat(vel);
			e.pos = cur_pos[31:0];
			e.vel = cur_vel[31:0];
			e.acc = 32'(sat(acc));
			e.fin = done_flag;
			pending.push_back(e);
		endfunction

		function void check_result(logic [95:0] d, logic fin);
			setpoint_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h finished %b", $time, d, fin);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.pos) begin
				$display("%0t: position expected %h actual %h", $time, e.pos, d[31:0]);
				errors++;
			end
			if (d[63:32] !== e.vel) begin
				$display("%0t: velocity expected %h actual %h", $time, e.vel, d[63:32]);
				errors++;
			end
			if (d[95:64] !== e.acc) begin
				$display("%0t: acceleration expected %h actual %h", $time, e.acc, d[95:64]);
				errors++;
			end
			if (fin !== e.fin) begin
				$display("%0t: finished expected %b actual %b", $time, e.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [95:0] m_tdata;
	logic        m_tuser;

	profile_scoreboard sb = new();
	bit stall_on = 0;
	bit send_gaps = 1;
	int ready_wait = 0;
	int quiet_cycles = 0;

	trapezoidal_motion_profile dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 10);
		return $urandom_range(20, 120);
	endfunction

	always @(posedge clk) begin
		if (ready_wait > 0) begin
			ready_wait--;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
			if (stall_on && $urandom_range(0, 7) == 0) ready_wait = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_item(logic [31:0] tgt, logic [31:0] dt);
		int gap;
		gap = send_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {dt, tgt};
		do @(posedge clk); while (!s_tready);
		sb.note_input(tgt, dt);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, value);
	endtask

	// Drive one move: a new target, then a non-decreasing elapsed time through the profile.
	task automatic run_move(int unsigned span);
		logic [31:0] tgt, dt;
		int n;
		tgt = $signed(sb.cur_pos[31:0]) + $signed($urandom_range(0, span) - span / 2);
		if (tgt == sb.last_tgt[31:0]) tgt = tgt + 1;
		n = $urandom_range(3, 14);
		dt = 0;
		for (int i = 0; i < n; i++) begin
			send_item(tgt, dt);
			dt = dt + $urandom_range(0, 4 << 16);
		end
		if ($urandom_range(0, 2) != 0) send_item(tgt, 32'hFFFF_FFFF);
	endtask

	task automatic run_random(int count);
		int r;
		for (int k = 0; k < count; ) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				run_move(r < 5 ? 40 << 16 : 4 << 16);
				k += 9;
			end else if (r == 7) begin
				send_item($urandom, $urandom);
				k++;
			end else begin
				send_item(sb.last_tgt[31:0], $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
				k++;
			end
		end
	endtask

	initial begin
		logic [31:0] vsets [5];
		logic [31:0] asets [5];
		logic [31:0] psets [5];
		arst_n = 0;
		vsets = '{32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0003_0000, 32'hFFFF_8000};
		asets = '{32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0002_0000, 32'h8002_0000};
		psets = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF0_0000, 32'h0012_3456};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(32'h0, 32'h0);
		send_item(32'h0, 32'h0001_0000);
		send_item(32'h0005_0000, 32'h0);
		send_item(32'h0005_0000, 32'h0002_0000);
		send_item(32'h0005_0000, 32'h0003_8000);
		send_item(32'hFFFB_0000, 32'h0000_8000);
		send_item(32'hFFFB_0000, 32'h0004_0000);
		send_item(32'hFFFB_0000, 32'hFFFF_FFFF);
		send_item(32'hFFFB_4000, 32'h0);
		send_item(32'h7FFF_FFFF, 32'h0);
		send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'h8000_0000, 32'h0001_0000);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h0064_0000, 32'h0002_0000);
		send_item(32'h0064_0000, 32'h0032_0000);
		send_item(32'h0064_0000, 32'h0065_0000);
		drain();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		write_reg(REG_MAX_VELOCITY, 32'h0004_0000);
		send_item(32'h0000_4000, 32'h0000_4000);
		send_item(32'h0000_4000, 32'h0010_0000);
		send_item(32'h0020_0000, 32'h0001_0000);
		send_item(32'hFFE0_0000, 32'h0000_8000);
		drain();

		for (int p = 0; p < 5; p++) begin
			stall_on = p != 1;
			send_gaps = p != 2;
			write_reg(REG_MAX_VELOCITY, vsets[p]);
			write_reg(REG_MAX_ACCELERATION, asets[p]);
			write_reg(REG_INITIAL_POSITION, psets[p]);
			run_random(290);
			drain();
		end
		stall_on = 1;
		send_gaps = 1;
		write_reg(REG_MAX_VELOCITY, 32'h0000_8000);
		write_reg(REG_MAX_ACCELERATION, 32'h0004_0000);
		run_move(8 << 16);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tmp_pkg.sv
rtl/tmp_unit.sv
rtl/trapezoidal_motion_profile.sv
test/tb_trapezoidal_motion_profile.sv
